@@ src/srenc_pkg.sv @@
package srenc_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int VALUE_WIDTH = 32;

    // Widths of the fixed-point datapath
    localparam int P10W  = 27;                       // 10^8 fits
    localparam int MAGMW = 10;                       // |M| up to 512
    localparam int PRODW = VALUE_WIDTH + P10W;
    localparam int BSW   = MAGMW + P10W + 1;
    localparam int DEN0W = MAGMW + P10W;
    localparam int NUMW  = ((PRODW > BSW + FRAC_BITS) ? PRODW : BSW + FRAC_BITS) + 2;
    localparam int DENW  = DEN0W + FRAC_BITS;
    localparam int NW    = ((NUMW + 1 > DENW) ? NUMW + 1 : DENW) + 1;
    localparam int QB    = 10;                       // quotient bits; bit 9 flags overflow
    localparam int RW    = ((NW > DENW + QB) ? NW : DENW + QB) + 1;

    localparam int QDEPTH = 4;
    localparam int QPW    = $clog2(QDEPTH);

    localparam logic [1:0] MODE_SIGNED   = 2'd1;
    localparam logic [1:0] MODE_INVERTED = 2'd2;

    typedef enum logic [2:0] {
        CFG_COEFF_M   = 3'd0,
        CFG_OFFSET_B  = 3'd1,
        CFG_EXPONENT  = 3'd2,
        CFG_MODE      = 3'd3,
        CFG_THR_EN    = 3'd4,
        CFG_LOWER     = 3'd5,
        CFG_UPPER     = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic signed [9:0] coeff_m;
        logic signed [9:0] offset_b;
        logic signed [3:0] result_exponent;
        logic [1:0]        reading_mode;
        logic [5:0]        threshold_enable;
        logic [23:0]       lower_codes;
        logic [23:0]       upper_codes;
    } srenc_cfg_t;

    // One classified request: rounding numerator 2|num|+den and the raw divisor
    typedef struct packed {
        logic [NW-1:0]    n;
        logic [DEN0W-1:0] den;
        logic             neg;
        logic             mzero;
    } srenc_item_t;

    function automatic logic [P10W-1:0] pow10(input logic [3:0] k);
        logic [P10W-1:0] r;
        case (k)
            4'd0:    r = P10W'(1);
            4'd1:    r = P10W'(10);
            4'd2:    r = P10W'(100);
            4'd3:    r = P10W'(1000);
            4'd4:    r = P10W'(10000);
            4'd5:    r = P10W'(100000);
            4'd6:    r = P10W'(1000000);
            4'd7:    r = P10W'(10000000);
            4'd8:    r = P10W'(100000000);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

@@ src/sensor_reading_encode_threshold.sv @@
// Channel   Dir  Ports                    Contents
// s_        in   s_tvalid/tready/tdata    sample value, Q16.16 signed
// m_        out  m_tvalid/tready/tdata    reading, threshold events, saturated
// cfg_      in   cfg_we/index/wdata       seven setup registers, write only
//
// One request per cycle is taken and one result per cycle leaves unless m_ stalls;
// the path runs through 3 front stages, the queue, 11 divider stages, clamp and
// output register. Throughput is set by the fully pipelined bit-per-stage divider.
// Reset (aresetn low, synchronous) empties all stages and loads register defaults.
// A stall on m_ holds the back pipeline; the 4-entry queue absorbs the front
// until it fills, then s_tready drops.
module sensor_reading_encode_threshold import srenc_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [VALUE_WIDTH-1:0] s_tdata,   // [31:0] sample value
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [15:0]            m_tdata,   // [7:0] reading, [13:8] threshold events,
                                              // [14] saturated, [15] zero
    input  logic                   cfg_we,
    input  logic [2:0]             cfg_index,
    input  logic [23:0]            cfg_wdata
);

    srenc_cfg_t  cfg_reg;
    srenc_item_t front_item;
    srenc_item_t head_item;
    logic        front_valid;
    logic        q_full;
    logic        q_empty;
    logic        q_pop;
    logic        q_push;
    logic [7:0]  reading;
    logic [5:0]  thr_events;
    logic        saturated;

    // setup registers: take a write whenever enabled, ignore unused indexes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.coeff_m          <= 10'sd1;
            cfg_reg.offset_b         <= 10'sd0;
            cfg_reg.result_exponent  <= 4'sd0;
            cfg_reg.reading_mode     <= 2'd0;
            cfg_reg.threshold_enable <= 6'd0;
            cfg_reg.lower_codes      <= 24'd0;
            cfg_reg.upper_codes      <= 24'd0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_COEFF_M:  cfg_reg.coeff_m          <= $signed(cfg_wdata[9:0]);
                CFG_OFFSET_B: cfg_reg.offset_b         <= $signed(cfg_wdata[9:0]);
                CFG_EXPONENT: cfg_reg.result_exponent  <= $signed(cfg_wdata[3:0]);
                CFG_MODE:     cfg_reg.reading_mode     <= cfg_wdata[1:0];
                CFG_THR_EN:   cfg_reg.threshold_enable <= cfg_wdata[5:0];
                CFG_LOWER:    cfg_reg.lower_codes      <= cfg_wdata;
                CFG_UPPER:    cfg_reg.upper_codes      <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // front: scale, subtract offset, form the rounding numerator
    srenc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_value  (s_tdata),
        .out_valid (front_valid),
        .out_ready (!q_full),
        .out_item  (front_item)
    );

    // push a classified request whenever the queue has room
    assign q_push = front_valid && !q_full;

    srenc_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (front_item),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head_item (head_item)
    );

    // back: divide, clamp, compare thresholds, hold the result
    srenc_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .in_valid    (!q_empty),
        .in_item     (head_item),
        .in_pop      (q_pop),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .m_reading   (reading),
        .m_events    (thr_events),
        .m_saturated (saturated)
    );

    assign m_tdata = {1'b0, saturated, thr_events, reading};

endmodule

@@ src/srenc_front.sv @@
module srenc_front import srenc_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  srenc_cfg_t             cfg,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [VALUE_WIDTH-1:0] in_value,
    output logic                   out_valid,
    input  logic                   out_ready,
    output srenc_item_t            out_item
);

    logic adv;

    // stage 1: scale products
    logic                          s1_valid_reg;
    logic [PRODW-1:0]              s1_prod_reg;
    logic signed [VALUE_WIDTH-1:0] s1_v_reg;
    logic                          s1_vneg_reg;
    logic signed [BSW-1:0]         s1_b_reg;
    logic [DEN0W-1:0]              s1_den_reg;
    logic                          s1_epos_reg;
    logic                          s1_mneg_reg;
    logic                          s1_mzero_reg;

    // stage 2: signed numerator
    logic                   s2_valid_reg;
    logic signed [NUMW-1:0] s2_num_reg;
    logic [DEN0W-1:0]       s2_den_reg;
    logic                   s2_mneg_reg;
    logic                   s2_mzero_reg;

    // stage 3: magnitude and sign
    logic             s3_valid_reg;
    logic [NUMW-1:0]  s3_mag_reg;
    logic [DEN0W-1:0] s3_den_reg;
    logic             s3_neg_reg;
    logic             s3_mzero_reg;

    logic                          epos;
    logic [3:0]                    k;
    logic [P10W-1:0]               p10;
    logic [VALUE_WIDTH-1:0]        vmag;
    logic [MAGMW-1:0]              mmag;
    logic signed [BSW-1:0]         b_next;
    logic [PRODW-1:0]              prod_next;
    logic [DEN0W-1:0]              den_next;
    logic signed [NUMW-1:0]        vterm;
    logic signed [NUMW-1:0]        bterm;
    logic signed [NUMW-1:0]        num_next;

    assign adv       = !(s3_valid_reg && !out_ready);
    assign in_ready  = adv;
    assign out_valid = s3_valid_reg;

    always_comb begin
        epos = !cfg.result_exponent[3] && (cfg.result_exponent != 4'sd0);
        k    = epos ? cfg.result_exponent : 4'(-cfg.result_exponent);
        p10  = pow10(k);
        vmag = in_value[VALUE_WIDTH-1] ? VALUE_WIDTH'(-in_value) : in_value;
        mmag = cfg.coeff_m[9] ? MAGMW'(-cfg.coeff_m) : MAGMW'(cfg.coeff_m);
        prod_next = PRODW'(vmag) * PRODW'(p10);
        if (epos) begin
            b_next = BSW'(cfg.offset_b) * BSW'($signed({1'b0, p10}));
        end else begin
            b_next = BSW'(cfg.offset_b);
        end
        den_next = DEN0W'(mmag) * DEN0W'(epos ? p10 : P10W'(1));
    end

    always_comb begin
        if (s1_epos_reg) begin
            vterm = NUMW'(s1_v_reg);
        end else if (s1_vneg_reg) begin
            vterm = -$signed(NUMW'(s1_prod_reg));
        end else begin
            vterm = $signed(NUMW'(s1_prod_reg));
        end
        bterm    = NUMW'(s1_b_reg) <<< FRAC_BITS;
        num_next = vterm - bterm;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_prod_reg  <= prod_next;
            s1_v_reg     <= $signed(in_value);
            s1_vneg_reg  <= in_value[VALUE_WIDTH-1];
            s1_b_reg     <= b_next;
            s1_den_reg   <= den_next;
            s1_epos_reg  <= epos;
            s1_mneg_reg  <= cfg.coeff_m[9];
            s1_mzero_reg <= (cfg.coeff_m == 10'sd0);

            s2_num_reg   <= num_next;
            s2_den_reg   <= s1_den_reg;
            s2_mneg_reg  <= s1_mneg_reg;
            s2_mzero_reg <= s1_mzero_reg;

            s3_mag_reg   <= s2_num_reg[NUMW-1] ? NUMW'(-s2_num_reg) : NUMW'(s2_num_reg);
            s3_neg_reg   <= s2_num_reg[NUMW-1] ^ s2_mneg_reg;
            s3_den_reg   <= s2_den_reg;
            s3_mzero_reg <= s2_mzero_reg;
        end
    end

    // rounding numerator 2|num| + den, den = |M|*scale*2^F
    always_comb begin
        out_item.n     = (NW'(s3_mag_reg) << 1) + NW'({s3_den_reg, {FRAC_BITS{1'b0}}});
        out_item.den   = s3_den_reg;
        out_item.neg   = s3_neg_reg;
        out_item.mzero = s3_mzero_reg;
    end

endmodule

@@ src/srenc_fifo.sv @@
module srenc_fifo import srenc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  srenc_item_t push_item,
    output logic        full,
    input  logic        pop,
    output logic        empty,
    output srenc_item_t head_item
);

    srenc_item_t      mem_reg [QDEPTH];
    logic [QPW-1:0]   wp_reg;
    logic [QPW-1:0]   rp_reg;
    logic [QPW:0]     cnt_reg;

    assign full      = (cnt_reg == (QPW+1)'(QDEPTH));
    assign empty     = (cnt_reg == '0);
    assign head_item = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop) begin
                rp_reg <= rp_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= push_item;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("queue read while empty");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= (QPW+1)'(QDEPTH))
        else $error("queue count beyond depth");

endmodule

@@ src/srenc_back.sv @@
module srenc_back import srenc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  srenc_cfg_t  cfg,
    input  logic        in_valid,
    input  srenc_item_t in_item,
    output logic        in_pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_reading,
    output logic [5:0]  m_events,
    output logic        m_saturated
);

    logic adv;

    // divider pipeline: stage 0 holds the request, stage j retires quotient bit QB-j
    logic             dv_valid_reg [QB+1];
    logic [RW-1:0]    dv_rem_reg   [QB+1];
    logic [DEN0W-1:0] dv_den_reg   [QB+1];
    logic [QB-1:0]    dv_q_reg     [QB+1];
    logic             dv_neg_reg   [QB+1];
    logic             dv_mz_reg    [QB+1];

    logic [RW-1:0]    rem_next [QB+1];
    logic [QB-1:0]    q_next   [QB+1];

    // clamp stage
    logic       cl_valid_reg;
    logic [7:0] cl_r_reg;
    logic       cl_sat_reg;

    // result register
    logic       out_valid_reg;
    logic [7:0] out_r_reg;
    logic [5:0] out_ev_reg;
    logic       out_sat_reg;

    logic       sgn;
    logic       inv;
    logic [7:0] r_next;
    logic       sat_next;
    logic [5:0] ev_next;

    assign adv    = !out_valid_reg || m_ready;
    assign in_pop = adv && in_valid;
    assign sgn    = (cfg.reading_mode == MODE_SIGNED) || (cfg.reading_mode == MODE_INVERTED);
    assign inv    = (cfg.reading_mode == MODE_INVERTED);

    assign m_valid     = out_valid_reg;
    assign m_reading   = out_r_reg;
    assign m_events    = out_ev_reg;
    assign m_saturated = out_sat_reg;

    // restoring step: compare against the doubled divisor shifted to the bit weight
    always_comb begin
        logic [RW-1:0] dsh;
        rem_next[0] = RW'(in_item.n);
        q_next[0]   = '0;
        for (int j = 1; j <= QB; j++) begin
            dsh = RW'({dv_den_reg[j-1], {(FRAC_BITS+1){1'b0}}}) << (QB - j);
            if (dv_rem_reg[j-1] >= dsh) begin
                rem_next[j] = dv_rem_reg[j-1] - dsh;
                q_next[j]   = dv_q_reg[j-1] | (QB'(1) << (QB - j));
            end else begin
                rem_next[j] = dv_rem_reg[j-1];
                q_next[j]   = dv_q_reg[j-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j <= QB; j++) begin
                dv_valid_reg[j] <= 1'b0;
            end
            cl_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            dv_valid_reg[0] <= in_valid;
            for (int j = 1; j <= QB; j++) begin
                dv_valid_reg[j] <= dv_valid_reg[j-1];
            end
            cl_valid_reg  <= dv_valid_reg[QB];
            out_valid_reg <= cl_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dv_rem_reg[0] <= rem_next[0];
            dv_q_reg[0]   <= q_next[0];
            dv_den_reg[0] <= in_item.den;
            dv_neg_reg[0] <= in_item.neg;
            dv_mz_reg[0]  <= in_item.mzero;
            for (int j = 1; j <= QB; j++) begin
                dv_rem_reg[j] <= rem_next[j];
                dv_q_reg[j]   <= q_next[j];
                dv_den_reg[j] <= dv_den_reg[j-1];
                dv_neg_reg[j] <= dv_neg_reg[j-1];
                dv_mz_reg[j]  <= dv_mz_reg[j-1];
            end
            cl_r_reg    <= r_next;
            cl_sat_reg  <= sat_next;
            out_r_reg   <= cl_r_reg;
            out_ev_reg  <= ev_next;
            out_sat_reg <= cl_sat_reg;
        end
    end

    // clamp the rounded quotient; a set top bit already means far out of range
    always_comb begin
        logic [QB-1:0] q;
        q        = dv_q_reg[QB];
        r_next   = 8'd0;
        sat_next = 1'b0;
        if (dv_mz_reg[QB]) begin
            r_next   = 8'd0;
            sat_next = 1'b0;
        end else if (dv_neg_reg[QB]) begin
            if (sgn) begin
                if (q > QB'(128)) begin
                    r_next   = 8'h80;
                    sat_next = 1'b1;
                end else begin
                    r_next = 8'(-q);
                end
            end else begin
                r_next   = 8'd0;
                sat_next = (q != '0);
            end
        end else begin
            if (q > (sgn ? QB'(127) : QB'(255))) begin
                r_next   = sgn ? 8'h7F : 8'hFF;
                sat_next = 1'b1;
            end else begin
                r_next = q[7:0];
            end
        end
    end

    // threshold compare, bytes taken signed in the signed modes
    always_comb begin
        logic signed [8:0] rx;
        logic signed [8:0] cx;
        logic [7:0]        code;
        logic              lower;
        rx = $signed({sgn & cl_r_reg[7], cl_r_reg});
        for (int i = 0; i < 6; i++) begin
            lower = (i < 3);
            code  = lower ? cfg.lower_codes[8*(i%3) +: 8] : cfg.upper_codes[8*(i%3) +: 8];
            cx    = $signed({sgn & code[7], code});
            if (!cfg.threshold_enable[i]) begin
                ev_next[i] = 1'b0;
            end else if (lower != inv) begin
                ev_next[i] = (rx <= cx);
            end else begin
                ev_next[i] = (rx >= cx);
            end
        end
    end

    a_sat_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (cl_valid_reg && cl_sat_reg) |->
            (cl_r_reg == 8'h00 || cl_r_reg == 8'hFF || cl_r_reg == 8'h80 || cl_r_reg == 8'h7F))
        else $error("saturated reading not at a range limit");

    a_zero_coeff: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && dv_valid_reg[QB] && dv_mz_reg[QB]) |=> (cl_r_reg == 8'h00 && !cl_sat_reg))
        else $error("zero coefficient gave nonzero reading");

    a_drain_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && cl_valid_reg) |=> out_valid_reg)
        else $error("clamped result lost before the output register");

endmodule
